// File: src/ttf_pkg.sv
// ----------------------------------------------------------------------------
// ttf_pkg: shared types and constants of the triangle tangent frame
// Vertex and frame payload types, and the multiply-accumulate unit's operation codes.
// ----------------------------------------------------------------------------
package ttf_pkg;

  localparam int unsigned CoordW = 32;
  localparam int unsigned FracW  = 16;

  typedef struct packed {
    logic signed [CoordW-1:0] pos_x;
    logic signed [CoordW-1:0] pos_y;
    logic signed [CoordW-1:0] pos_z;
    logic signed [CoordW-1:0] tex_u;
    logic signed [CoordW-1:0] tex_v;
  } vertex_t;

  typedef struct packed {
    logic signed [CoordW-1:0] tangent_x;
    logic signed [CoordW-1:0] tangent_y;
    logic signed [CoordW-1:0] tangent_z;
    logic signed [CoordW-1:0] bitangent_x;
    logic signed [CoordW-1:0] bitangent_y;
    logic signed [CoordW-1:0] bitangent_z;
    logic signed [CoordW-1:0] normal_x;
    logic signed [CoordW-1:0] normal_y;
    logic signed [CoordW-1:0] normal_z;
    logic                     degenerate;
    logic                     saturated;
  } frame_t;

  // Shared multiply-accumulate unit operations
  typedef enum logic [1:0] {
    MAC_LOAD = 2'd0,  // acc = a*b
    MAC_SUB  = 2'd1,  // acc = acc - a*b
    MAC_NEG  = 2'd2   // acc = -(a*b)
  } mac_op_e;

  typedef struct packed {
    logic    start;
    mac_op_e op;
  } mac_ctrl_t;

endpackage

// File: src/triangle_tangent_frame.sv
// ----------------------------------------------------------------------------
// triangle_tangent_frame: per-triangle tangent, bitangent and normal
// Holds two vertices, and on the third computes the tangent frame through one
// shared multiply-accumulate unit and an iterative reciprocal.
// ----------------------------------------------------------------------------
//  channel | signals                      | payload
//  vertex  | vtx_valid_i / vtx_stall_o    | vertex_t vtx_i
//  frame   | frm_valid_o / frm_stall_i    | frame_t  frm_o
//
//  First and second vertex: taken without a stall, no frame.
//  Third vertex: the frame takes the bit-serial reciprocal and 26 products on
//  one multiplier; when the UV determinant is zero, only the two determinant
//  products are made and the reciprocal is skipped.
//  Reset clears the vertex count and the sequencer; held vertices stay unset.
//  A stalled frame holds the output register; a finished next frame waits in
//  the sequencer, which keeps the vertex channel stalled meanwhile.
// ----------------------------------------------------------------------------
module triangle_tangent_frame
  import ttf_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    vtx_valid_i,
  output logic    vtx_stall_o,
  input  vertex_t vtx_i,
  output logic    frm_valid_o,
  input  logic    frm_stall_i,
  output frame_t  frm_o
);

  localparam int unsigned W    = CoordW;
  localparam int unsigned F    = FracW;
  localparam int unsigned AccW = 2 * W + 2;
  localparam int unsigned QW   = 2 * W + 2;
  localparam logic signed [AccW-1:0] SMax = AccW'({1'b0, {(W-1){1'b1}}});
  localparam logic signed [AccW-1:0] SMin = -SMax - AccW'(1);
  localparam logic signed [AccW-1:0] Half = AccW'(1) <<< (F - 1);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_EDGE  = 9'b000000010,
    S_DET   = 9'b000000100,
    S_CHK   = 9'b000001000,
    S_RECIP = 9'b000010000,
    S_SUM   = 9'b000100000,
    S_TB    = 9'b001000000,
    S_NRM   = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  logic [1:0] vidx_q;
  logic [3:0] step_q;
  logic       clip_q;

  logic signed [W-1:0] hp_q [6];
  logic signed [W-1:0] ht_q [4];
  vertex_t             v2_q;
  logic signed [W-1:0] dp1_q [3];
  logic signed [W-1:0] dp2_q [3];
  logic signed [W-1:0] d1u_q, d1v_q, d2u_q, d2v_q, inv_q;
  logic signed [W-1:0] s_q [6];    // tangent sums, bitangent sums
  logic signed [W-1:0] tb_q [6];   // t xyz, b xyz
  logic signed [W-1:0] n_q [3];
  logic                neg_q;
  logic [AccW-1:0]     det_mag_q;

  frame_t frm_q;
  logic   frm_valid_q;

  logic                    acc_in;
  logic                    take_out;
  logic                    out_load;
  logic [1:0]              sum_k;
  mac_ctrl_t               mac_ctrl;
  logic signed [W-1:0]     mac_a, mac_b;
  logic signed [AccW-1:0]  acc;
  logic signed [AccW-1:0]  acc_rnd;
  logic                    rnd_clip, q_clip;
  logic signed [W-1:0]     rnd_sat;
  logic                    rc_start, rc_done;
  logic [QW-1:0]           quot;
  logic signed [QW:0]      qs;
  logic signed [W-1:0]     q_sat;

  assign vtx_stall_o = (state_q != S_IDLE);
  assign acc_in      = vtx_valid_i && !vtx_stall_o;
  assign take_out    = frm_valid_q && !frm_stall_i;
  // load the output register once it is empty or its frame leaves now
  assign out_load    = (state_q == S_OUT) && (!frm_valid_q || !frm_stall_i);

  // saturate helpers
  function automatic logic signed [W-1:0] sat_w(input logic signed [AccW-1:0] x);
    if (x > SMax) return SMax[W-1:0];
    if (x < SMin) return SMin[W-1:0];
    return x[W-1:0];
  endfunction
  function automatic logic clips(input logic signed [AccW-1:0] x);
    return (x > SMax) || (x < SMin);
  endfunction
  function automatic logic signed [W:0] dif(input logic signed [W-1:0] a,
                                             input logic signed [W-1:0] b);
    return (W+1)'(a) - (W+1)'(b);
  endfunction
  function automatic logic signed [W-1:0] sat_d(input logic signed [W:0] x);
    return sat_w(AccW'(x));
  endfunction
  function automatic logic clip_d(input logic signed [W:0] x);
    return clips(AccW'(x));
  endfunction

  // rounded, saturated accumulator
  assign acc_rnd  = (acc + Half) >>> F;
  assign rnd_sat  = sat_w(acc_rnd);
  assign rnd_clip = clips(acc_rnd);

  // signed, saturated quotient
  assign qs    = neg_q ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
  assign q_sat = (qs > (QW+1)'(SMax)) ? SMax[W-1:0] :
                 (qs < (QW+1)'(SMin)) ? SMin[W-1:0] : qs[W-1:0];
  assign q_clip = (qs > (QW+1)'(SMax)) || (qs < (QW+1)'(SMin));

  // component of the bitangent sum pair in progress
  assign sum_k = 2'(step_q[3:1] - 3'd3);

  // operand selection for the shared multiplier
  always_comb begin
    mac_ctrl = '{start: 1'b0, op: MAC_LOAD};
    mac_a    = '0;
    mac_b    = '0;
    unique case (state_q)
      S_DET: begin
        mac_ctrl.start = 1'b1;
        if (step_q == 4'd0) begin
          mac_a = d1u_q; mac_b = d2v_q;
        end else begin
          mac_a = d1v_q; mac_b = d2u_q; mac_ctrl.op = MAC_SUB;
        end
      end
      S_SUM: begin
        // step 2k / 2k+1: tangent sum k (k<3), bitangent sum k-3
        mac_ctrl.start = step_q < 4'd12;
        mac_ctrl.op    = step_q[0] ? MAC_SUB : MAC_LOAD;
        if (step_q < 4'd6) begin
          mac_a = step_q[0] ? dp2_q[step_q[2:1]] : dp1_q[step_q[2:1]];
          mac_b = step_q[0] ? d1v_q : d2v_q;
        end else if (step_q < 4'd12) begin
          mac_a = step_q[0] ? dp2_q[sum_k] : dp1_q[sum_k];
          mac_b = step_q[0] ? d2u_q : d1u_q;
        end
      end
      S_TB: begin
        mac_ctrl.start = step_q < 4'd6;
        mac_ctrl.op    = (step_q < 4'd3) ? MAC_LOAD : MAC_NEG;
        mac_a          = inv_q;
        mac_b          = (step_q < 4'd6) ? s_q[step_q[2:0]] : '0;
      end
      S_NRM: begin
        mac_ctrl.start = step_q < 4'd6;
        mac_ctrl.op    = step_q[0] ? MAC_SUB : MAC_LOAD;
        unique case (step_q)
          4'd0:    begin mac_a = tb_q[1]; mac_b = tb_q[5]; end
          4'd1:    begin mac_a = tb_q[2]; mac_b = tb_q[4]; end
          4'd2:    begin mac_a = tb_q[2]; mac_b = tb_q[3]; end
          4'd3:    begin mac_a = tb_q[0]; mac_b = tb_q[5]; end
          4'd4:    begin mac_a = tb_q[0]; mac_b = tb_q[4]; end
          4'd5:    begin mac_a = tb_q[1]; mac_b = tb_q[3]; end
          default: begin mac_a = '0; mac_b = '0; end
        endcase
      end
      default: ;
    endcase
  end

  ttf_mac #(.OpW(W), .AccW(AccW)) u_mac (
    .clk_i  (clk_i),
    .ctrl_i (mac_ctrl),
    .a_i    (mac_a),
    .b_i    (mac_b),
    .acc_o  (acc)
  );

  assign rc_start = (state_q == S_CHK) && (acc != '0);

  ttf_recip #(.DetW(AccW), .QW(QW), .NumSh(3 * F)) u_recip (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (rc_start),
    .mag_i   (acc[AccW-1] ? AccW'(-acc) : acc),
    .done_o  (rc_done),
    .quot_o  (quot)
  );

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (acc_in && vidx_q == 2'd2) state_d = S_EDGE;
      S_EDGE:  state_d = S_DET;
      S_DET:   if (step_q == 4'd1) state_d = S_CHK;
      S_CHK:   state_d = (acc == '0) ? S_OUT : S_RECIP;
      S_RECIP: if (rc_done) state_d = S_SUM;
      S_SUM:   if (step_q == 4'd12) state_d = S_TB;
      S_TB:    if (step_q == 4'd6) state_d = S_NRM;
      S_NRM:   if (step_q == 4'd6) state_d = S_OUT;
      S_OUT:   if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      vidx_q      <= 2'd0;
      step_q      <= '0;
      frm_valid_q <= 1'b0;
      clip_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= (state_d != state_q) ? 4'd0 : step_q + 4'd1;
      if (acc_in) vidx_q <= (vidx_q == 2'd2) ? 2'd0 : vidx_q + 2'd1;
      if (state_q == S_EDGE) begin
        clip_q <= clip_d(dif(hp_q[3], hp_q[0])) | clip_d(dif(hp_q[4], hp_q[1]))
                | clip_d(dif(hp_q[5], hp_q[2])) | clip_d(dif(v2_q.pos_x, hp_q[0]))
                | clip_d(dif(v2_q.pos_y, hp_q[1])) | clip_d(dif(v2_q.pos_z, hp_q[2]))
                | clip_d(dif(ht_q[2], ht_q[0])) | clip_d(dif(ht_q[3], ht_q[1]))
                | clip_d(dif(v2_q.tex_u, ht_q[0])) | clip_d(dif(v2_q.tex_v, ht_q[1]));
      end else if (state_q == S_RECIP && rc_done) begin
        clip_q <= clip_q | q_clip;
      end else if ((state_q == S_SUM && step_q != 4'd0 && !step_q[0]) ||
                   (state_q != S_SUM && state_q != S_DET && state_q != S_CHK &&
                    state_q != S_RECIP && step_q != 4'd0 &&
                    (state_q == S_TB || (state_q == S_NRM && !step_q[0])))) begin
        clip_q <= clip_q | rnd_clip;
      end
      // output register
      if (out_load)      frm_valid_q <= 1'b1;
      else if (take_out) frm_valid_q <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (acc_in) begin
      if (vidx_q == 2'd0) begin
        hp_q[0] <= vtx_i.pos_x; hp_q[1] <= vtx_i.pos_y; hp_q[2] <= vtx_i.pos_z;
        ht_q[0] <= vtx_i.tex_u; ht_q[1] <= vtx_i.tex_v;
      end else if (vidx_q == 2'd1) begin
        hp_q[3] <= vtx_i.pos_x; hp_q[4] <= vtx_i.pos_y; hp_q[5] <= vtx_i.pos_z;
        ht_q[2] <= vtx_i.tex_u; ht_q[3] <= vtx_i.tex_v;
      end else begin
        v2_q <= vtx_i;
      end
    end
    if (state_q == S_EDGE) begin
      dp1_q[0] <= sat_d(dif(hp_q[3], hp_q[0]));
      dp1_q[1] <= sat_d(dif(hp_q[4], hp_q[1]));
      dp1_q[2] <= sat_d(dif(hp_q[5], hp_q[2]));
      dp2_q[0] <= sat_d(dif(v2_q.pos_x, hp_q[0]));
      dp2_q[1] <= sat_d(dif(v2_q.pos_y, hp_q[1]));
      dp2_q[2] <= sat_d(dif(v2_q.pos_z, hp_q[2]));
      d1u_q    <= sat_d(dif(ht_q[2], ht_q[0]));
      d1v_q    <= sat_d(dif(ht_q[3], ht_q[1]));
      d2u_q    <= sat_d(dif(v2_q.tex_u, ht_q[0]));
      d2v_q    <= sat_d(dif(v2_q.tex_v, ht_q[1]));
    end
    if (state_q == S_CHK) neg_q <= acc[AccW-1];
    if (state_q == S_RECIP && rc_done) inv_q <= q_sat;
    // accumulator holds a pair's result in the cycle after its second product
    if (state_q == S_SUM && step_q != 4'd0 && !step_q[0]) s_q[step_q[3:1] - 3'd1] <= rnd_sat;
    if (state_q == S_TB && step_q != 4'd0) tb_q[step_q[2:0] - 3'd1] <= rnd_sat;
    if (state_q == S_NRM && step_q != 4'd0 && !step_q[0]) n_q[step_q[2:1] - 2'd1] <= rnd_sat;
    // zero determinant: zero vectors, flag degenerate, no clip reported
    if (out_load) begin
      frm_q.tangent_x   <= tb_q[0];
      frm_q.tangent_y   <= tb_q[1];
      frm_q.tangent_z   <= tb_q[2];
      frm_q.bitangent_x <= tb_q[3];
      frm_q.bitangent_y <= tb_q[4];
      frm_q.bitangent_z <= tb_q[5];
      frm_q.normal_x    <= n_q[0];
      frm_q.normal_y    <= n_q[1];
      frm_q.normal_z    <= n_q[2];
      frm_q.degenerate  <= (det_mag_q == '0);
      frm_q.saturated   <= clip_q && (det_mag_q != '0);
    end
    if (state_q == S_CHK && acc == '0) begin
      for (int i = 0; i < 6; i++) tb_q[i] <= '0;
      for (int i = 0; i < 3; i++) n_q[i] <= '0;
    end
    if (state_q == S_CHK) det_mag_q <= acc;
  end

  assign frm_valid_o = frm_valid_q;
  assign frm_o       = frm_q;

`ifndef NO_ASSERTIONS
  a_busy_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> vtx_stall_o) else $error("vertex taken while busy");
  a_out_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> frm_valid_o) else $error("frame not presented");
  a_vidx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vidx_q != 2'd3) else $error("vertex count out of range");
  a_frm_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (frm_valid_o && frm_stall_i) |=> (frm_valid_o && $stable(frm_o)))
    else $error("stalled frame changed");
`endif

endmodule

// File: src/ttf_mac.sv
// ----------------------------------------------------------------------------
// ttf_mac: shared multiply-accumulate unit
// One signed product per cycle into a wide accumulator; the result is
// registered before it can be used again.
// ----------------------------------------------------------------------------
module ttf_mac
  import ttf_pkg::*;
#(
  parameter int unsigned OpW  = 32,
  parameter int unsigned AccW = 2 * OpW + 2
) (
  input  logic                   clk_i,
  input  mac_ctrl_t              ctrl_i,
  input  logic signed [OpW-1:0]  a_i,
  input  logic signed [OpW-1:0]  b_i,
  output logic signed [AccW-1:0] acc_o
);

  logic signed [2*OpW-1:0] prod;
  logic signed [AccW-1:0]  prod_x;
  logic signed [AccW-1:0]  acc_d, acc_q;

  assign prod   = a_i * b_i;
  assign prod_x = AccW'(prod);

  // accumulate
  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.start) begin
      unique case (ctrl_i.op)
        MAC_LOAD: acc_d = prod_x;
        MAC_SUB:  acc_d = acc_q - prod_x;
        MAC_NEG:  acc_d = -prod_x;
        default:  acc_d = prod_x;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  assign acc_o = acc_q;

endmodule

// File: src/ttf_recip.sv
// ----------------------------------------------------------------------------
// ttf_recip: iterative reciprocal
// Restoring division of 2^(3*FRAC) by the determinant magnitude, one quotient
// bit per cycle.
// ----------------------------------------------------------------------------
module ttf_recip
  import ttf_pkg::*;
#(
  parameter int unsigned DetW  = 66,
  parameter int unsigned QW    = 66,
  parameter int unsigned NumSh = 48
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [DetW-1:0] mag_i,
  output logic            done_o,
  output logic [QW-1:0]   quot_o
);

  localparam int unsigned CntW = $clog2(QW + 1);

  logic [DetW:0]   rem_q, rem_d, trial;
  logic [QW-1:0]   quot_q, quot_d;
  logic [DetW-1:0] div_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            nbit;

  // numerator bit entering at this step
  assign nbit  = (cnt_q == CntW'(NumSh + 1));
  assign trial = {rem_q[DetW-1:0], nbit};

  always_comb begin
    rem_d  = rem_q;
    quot_d = quot_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      rem_d  = '0;
      quot_d = '0;
      cnt_d  = CntW'(QW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (cnt_q != '0) begin
        // shift one bit, subtract when it fits
        if (trial >= {1'b0, div_q}) begin
          rem_d  = trial - {1'b0, div_q};
          quot_d = {quot_q[QW-2:0], 1'b1};
        end else begin
          rem_d  = trial;
          quot_d = {quot_q[QW-2:0], 1'b0};
        end
        cnt_d = cnt_q - 1'b1;
      end else begin
        // all quotient bits are in the register: finish
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quot_q <= quot_d;
    if (start_i) div_q <= mag_i;
  end

  assign done_o = busy_q && (cnt_q == '0);
  assign quot_o = quot_q;

endmodule

// File: tb/sv/triangle_tangent_frame_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// triangle_tangent_frame_tb: self-checking bench of the tangent frame block
// Streams vertices into the block, predicts each triangle's frame in 128-bit
// arithmetic and compares every transfer on the frame channel field by field.
// ----------------------------------------------------------------------------
module triangle_tangent_frame_tb
  import ttf_pkg::*;
();

  localparam int unsigned MaxCycles = 2_000_000;

  logic    clk_i;
  logic    rst_ni;
  logic    vtx_valid_i;
  logic    vtx_stall_o;
  vertex_t vtx_i;
  logic    frm_valid_o;
  logic    frm_stall_i;
  frame_t  frm_o;

  triangle_tangent_frame dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .vtx_valid_i(vtx_valid_i),
    .vtx_stall_o(vtx_stall_o),
    .vtx_i      (vtx_i),
    .frm_valid_o(frm_valid_o),
    .frm_stall_i(frm_stall_i),
    .frm_o      (frm_o)
  );

  // Frame predictor state
  logic signed [CoordW-1:0] corner_pos[6];
  logic signed [CoordW-1:0] corner_tex[4];
  int unsigned              corner_cnt;
  logic                     clip_flag;
  frame_t                   frame_queue[$];

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned hold_off_cycles;
  int unsigned error_cnt;
  int unsigned cycle_cnt;

  // Clock and cycle-limit watchdog
  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > MaxCycles) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Round off the fraction bits, ties toward plus infinity
  function automatic logic signed [127:0] round_frac(input logic signed [127:0] a);
    return (a + (128'sd1 <<< (FracW - 1))) >>> FracW;
  endfunction

  // Clip to the coordinate range, noting any clip
  function automatic logic signed [CoordW-1:0] clip_coord(input logic signed [127:0] a);
    logic signed [127:0] hi;
    logic signed [127:0] lo;
    hi = (128'sd1 <<< (CoordW - 1)) - 1;
    lo = -(128'sd1 <<< (CoordW - 1));
    if (a > hi) begin
      clip_flag = 1'b1;
      return hi[CoordW-1:0];
    end
    if (a < lo) begin
      clip_flag = 1'b1;
      return lo[CoordW-1:0];
    end
    return a[CoordW-1:0];
  endfunction

  function automatic logic signed [127:0] wide(input logic signed [CoordW-1:0] v);
    return 128'(v);
  endfunction

  // Take one vertex; queue the frame when it closes a triangle
  task automatic predict_frame(input vertex_t v);
    logic signed [CoordW-1:0] dp1[3], dp2[3], t[3], b[3], n[3], s, s2;
    logic signed [CoordW-1:0] d1u, d1v, d2u, d2v, inv;
    logic signed [CoordW-1:0] p[3];
    logic signed [127:0]      det, q;
    frame_t                   f;
    p[0] = v.pos_x;
    p[1] = v.pos_y;
    p[2] = v.pos_z;
    if (corner_cnt < 2) begin
      for (int c = 0; c < 3; c++) corner_pos[corner_cnt*3 + c] = p[c];
      corner_tex[corner_cnt*2]     = v.tex_u;
      corner_tex[corner_cnt*2 + 1] = v.tex_v;
      corner_cnt++;
      return;
    end
    corner_cnt = 0;
    clip_flag  = 1'b0;
    for (int c = 0; c < 3; c++) begin
      dp1[c] = clip_coord(wide(corner_pos[3+c]) - wide(corner_pos[c]));
      dp2[c] = clip_coord(wide(p[c]) - wide(corner_pos[c]));
    end
    d1u = clip_coord(wide(corner_tex[2]) - wide(corner_tex[0]));
    d1v = clip_coord(wide(corner_tex[3]) - wide(corner_tex[1]));
    d2u = clip_coord(wide(v.tex_u) - wide(corner_tex[0]));
    d2v = clip_coord(wide(v.tex_v) - wide(corner_tex[1]));
    det = wide(d1u) * wide(d2v) - wide(d1v) * wide(d2u);
    f = '0;
    if (det == 0) begin
      f.degenerate = 1'b1;
      frame_queue = {frame_queue, f};
      return;
    end
    // Signed division truncates toward zero
    q   = (128'sd1 <<< (3 * FracW)) / det;
    inv = clip_coord(q);
    for (int c = 0; c < 3; c++) begin
      s  = clip_coord(round_frac(wide(dp1[c]) * wide(d2v) - wide(dp2[c]) * wide(d1v)));
      s2 = clip_coord(round_frac(wide(dp1[c]) * wide(d1u) - wide(dp2[c]) * wide(d2u)));
      t[c] = clip_coord(round_frac(wide(inv) * wide(s)));
      b[c] = clip_coord(round_frac(-(wide(inv) * wide(s2))));
    end
    n[0] = clip_coord(round_frac(wide(t[1]) * wide(b[2]) - wide(t[2]) * wide(b[1])));
    n[1] = clip_coord(round_frac(wide(t[2]) * wide(b[0]) - wide(t[0]) * wide(b[2])));
    n[2] = clip_coord(round_frac(wide(t[0]) * wide(b[1]) - wide(t[1]) * wide(b[0])));
    f.tangent_x   = t[0];
    f.tangent_y   = t[1];
    f.tangent_z   = t[2];
    f.bitangent_x = b[0];
    f.bitangent_y = b[1];
    f.bitangent_z = b[2];
    f.normal_x    = n[0];
    f.normal_y    = n[1];
    f.normal_z    = n[2];
    f.saturated   = clip_flag;
    frame_queue = {frame_queue, f};
  endtask

  // Send one vertex, idling at random beforehand; valid stays up until the
  // next call or the next drain decides otherwise
  task automatic send_vertex(input vertex_t v);
    while ($urandom_range(99) < send_idle_pct) begin
      vtx_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    vtx_valid_i <= 1'b1;
    vtx_i       <= v;
    @(posedge clk_i);
    while (vtx_stall_o) @(posedge clk_i);
    predict_frame(v);
  endtask

  task automatic send_tri(input vertex_t a, input vertex_t b, input vertex_t c);
    send_vertex(a);
    send_vertex(b);
    send_vertex(c);
  endtask

  function automatic logic [CoordW-1:0] rand_coord(input int unsigned mode);
    case (mode)
      0: return $urandom();
      1: return CoordW'($signed($urandom_range(8192)) - 4096) <<< FracW;
      2: return CoordW'($signed($urandom_range(131072)) - 65536) <<< 6;
      default: return CoordW'($signed($urandom_range(2000000)) - 1000000);
    endcase
  endfunction

  function automatic vertex_t rand_vertex(input int unsigned mode);
    vertex_t v;
    v.pos_x = rand_coord(mode);
    v.pos_y = rand_coord(mode);
    v.pos_z = rand_coord(mode);
    v.tex_u = rand_coord(mode);
    v.tex_v = rand_coord(mode);
    return v;
  endfunction

  function automatic vertex_t mk(input int px, input int py, input int pz,
                                 input int tu, input int tv);
    vertex_t v;
    v.pos_x = px;
    v.pos_y = py;
    v.pos_z = pz;
    v.tex_u = tu;
    v.tex_v = tv;
    return v;
  endfunction

  // Drop valid and wait for every queued frame to drain
  task automatic drain_frames();
    vtx_valid_i <= 1'b0;
    while (frame_queue.size() != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
  endtask

  // Receiver: random stall, plus a long hold-off on request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frm_stall_i <= 1'b1;
    end else if (hold_off_cycles != 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      frm_stall_i     <= 1'b1;
    end else begin
      frm_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Check each frame transfer against the oldest prediction
  always @(posedge clk_i) begin
    frame_t e;
    if (rst_ni && frm_valid_o && !frm_stall_i) begin
      if (frame_queue.size() == 0) begin
        $error("frame transfer with no frame expected");
        error_cnt++;
      end else begin
        e = frame_queue.pop_front();
        if (frm_o.tangent_x !== e.tangent_x) begin
          $error("tangent_x exp %0d got %0d", e.tangent_x, frm_o.tangent_x); error_cnt++;
        end
        if (frm_o.tangent_y !== e.tangent_y) begin
          $error("tangent_y exp %0d got %0d", e.tangent_y, frm_o.tangent_y); error_cnt++;
        end
        if (frm_o.tangent_z !== e.tangent_z) begin
          $error("tangent_z exp %0d got %0d", e.tangent_z, frm_o.tangent_z); error_cnt++;
        end
        if (frm_o.bitangent_x !== e.bitangent_x) begin
          $error("bitangent_x exp %0d got %0d", e.bitangent_x, frm_o.bitangent_x);
          error_cnt++;
        end
        if (frm_o.bitangent_y !== e.bitangent_y) begin
          $error("bitangent_y exp %0d got %0d", e.bitangent_y, frm_o.bitangent_y);
          error_cnt++;
        end
        if (frm_o.bitangent_z !== e.bitangent_z) begin
          $error("bitangent_z exp %0d got %0d", e.bitangent_z, frm_o.bitangent_z);
          error_cnt++;
        end
        if (frm_o.normal_x !== e.normal_x) begin
          $error("normal_x exp %0d got %0d", e.normal_x, frm_o.normal_x); error_cnt++;
        end
        if (frm_o.normal_y !== e.normal_y) begin
          $error("normal_y exp %0d got %0d", e.normal_y, frm_o.normal_y); error_cnt++;
        end
        if (frm_o.normal_z !== e.normal_z) begin
          $error("normal_z exp %0d got %0d", e.normal_z, frm_o.normal_z); error_cnt++;
        end
        if (frm_o.degenerate !== e.degenerate) begin
          $error("degenerate exp %0b got %0b", e.degenerate, frm_o.degenerate);
          error_cnt++;
        end
        if (frm_o.saturated !== e.saturated) begin
          $error("saturated exp %0b got %0b", e.saturated, frm_o.saturated);
          error_cnt++;
        end
      end
    end
  end

  // Directed: unit frame, degenerate UVs, extremes and saturation
  task automatic test_directed();
    int one;
    one = 1 << FracW;
    send_tri(mk(0, 0, 0, 0, 0), mk(one, 0, 0, one, 0), mk(0, one, 0, 0, one));
    send_tri(mk(0, 0, 0, 0, 0), mk(one, 0, 0, one, one), mk(0, one, 0, 2*one, 2*one));
    send_tri(mk(1, 2, 3, 5, 5), mk(4, 5, 6, 5, 5), mk(7, 8, 9, 5, 5));
    send_tri(mk(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff),
             mk(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000),
             mk(32'h7fffffff, 32'h80000000, 0, 32'h80000000, 32'h7fffffff));
    send_tri(mk(0, 0, 0, 0, 0), mk(one, 2*one, -one, 1, 0), mk(-one, one, one, 0, 1));
    send_tri(mk(0, 0, 0, 0, 0), mk(one, one, one, 32'h7fffffff, 0),
             mk(one, -one, 0, 0, 32'h7fffffff));
    send_tri(mk(-1, -1, -1, -1, -1), mk(0, 0, 0, 0, 0), mk(1, 1, 1, 1, -1));
    send_tri(mk(32'h80000000, 0, 32'h7fffffff, 0, 0),
             mk(32'h7fffffff, 32'h7fffffff, 32'h80000000, 3*one, one),
             mk(0, 32'h80000000, 0, -one, 2*one));
    drain_frames();
  endtask

  task automatic test_random(input int unsigned tris, input int unsigned s_pct,
                             input int unsigned r_pct);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    for (int unsigned i = 0; i < tris; i++) begin
      int unsigned mode;
      mode = $urandom_range(3);
      send_tri(rand_vertex(mode), rand_vertex(mode), rand_vertex(mode));
    end
    drain_frames();
  endtask

  // Hold the receiver off long enough to back up the vertex channel
  task automatic test_backpressure();
    send_idle_pct   = 0;
    recv_idle_pct   = 0;
    hold_off_cycles = 1500;
    for (int unsigned i = 0; i < 8; i++)
      send_tri(rand_vertex(1), rand_vertex(1), rand_vertex(1));
    drain_frames();
  endtask

  initial begin
    rst_ni          = 1'b0;
    vtx_valid_i     = 1'b0;
    vtx_i           = '0;
    corner_cnt      = 0;
    error_cnt       = 0;
    cycle_cnt       = 0;
    hold_off_cycles = 0;
    send_idle_pct   = 0;
    recv_idle_pct   = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random(60, 24, 55);
    test_random(60, 55, 24);
    test_random(55, 0, 0);
    test_backpressure();

    if (error_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: files.f
src/ttf_pkg.sv
src/ttf_mac.sv
src/ttf_recip.sv
src/triangle_tangent_frame.sv
tb/sv/triangle_tangent_frame_tb.sv
